// File: rtl/core/sg3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 separable Sobel gradient block.
// No dependencies; used by the top, the checker and the testbench.
package sg3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = 12;
  localparam int unsigned PixW      = 8;
  localparam int unsigned WidthW    = 11;
  localparam int unsigned SumW      = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;
  localparam int unsigned OccW      = FifoCntW + 1;

  // Reset register values, stored as the last column / last row index.
  localparam logic [ColW-1:0] WidthLimReset  = ColW'(640 - 1);
  localparam logic [RowW-1:0] HeightLimReset = RowW'(480 - 1);
  localparam logic [WidthW-1:0] MinWidth     = WidthW'(3);
  localparam logic [WidthW-1:0] MaxWidthVal  = WidthW'(MaxWidth);
  localparam logic [RowW-1:0] MinHeight      = RowW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_idx_e;

  // One line buffer word holds both rows above for a column.
  typedef struct packed {
    logic [PixW-1:0] two_above;
    logic [PixW-1:0] above;
  } line_word_t;

  typedef struct packed {
    logic [PixW-1:0] gradient;
    logic            last;
  } result_t;

endpackage

// File: rtl/core/sobel_gradient_3x3_top.sv
`timescale 1ns / 1ps
// A result word goes through the stage 1 and stage 2 registers and then the result queue.
// Throughput: one pixel per cycle; the line buffer memory is read and written once per cycle.
// A 4-entry result queue absorbs output stalls; input stalls only when it would overflow.
// Reset: asynchronous, active low; clears counters, window, queue and registers
// (mode 0, width 640, height 480). Line buffer contents are undefined until written.
module sobel_gradient_3x3_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sg3_pkg::PixW-1:0]      pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sg3_pkg::PixW-1:0]      gradient_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sg3_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sg3_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Configuration registers
  logic                        mode_q;
  logic [sg3_pkg::ColW-1:0]    wlim_q;
  logic [sg3_pkg::RowW-1:0]    hlim_q;
  logic [sg3_pkg::WidthW-1:0]  cfg_w;
  logic [sg3_pkg::WidthW-1:0]  cfg_w_sat;
  logic [sg3_pkg::RowW-1:0]    cfg_h_sat;

  // Stage 0 counters
  logic [sg3_pkg::ColW-1:0]    col_q;
  logic [sg3_pkg::RowW-1:0]    row_q;
  logic                        accept;
  logic                        row_end;
  logic                        frame_end;

  // Line buffer memory
  sg3_pkg::line_word_t         line_mem [sg3_pkg::MaxWidth];
  sg3_pkg::line_word_t         rd_q;
  sg3_pkg::line_word_t         wr_word;

  // Stage 1
  logic                        p1_valid_q;
  logic                        p1_emit_q;
  logic                        p1_last_q;
  logic [sg3_pkg::PixW-1:0]    p1_px_q;
  logic [sg3_pkg::ColW-1:0]    p1_addr_q;

  // Stage 2
  logic [sg3_pkg::PixW-1:0]    win_q [9];
  logic                        p2_valid_q;
  logic                        p2_last_q;
  logic signed [sg3_pkg::SumW-1:0] col_a [3];
  logic signed [sg3_pkg::SumW-1:0] sum;
  logic [sg3_pkg::SumW-1:0]    mag;
  sg3_pkg::result_t            res;

  // Result queue
  sg3_pkg::result_t            fifo_q [sg3_pkg::FifoDepth];
  logic [sg3_pkg::FifoPtrW-1:0] wr_ptr_q;
  logic [sg3_pkg::FifoPtrW-1:0] rd_ptr_q;
  logic [sg3_pkg::FifoCntW-1:0] cnt_q;
  logic [sg3_pkg::OccW-1:0]    occ;
  logic                        push;
  logic                        pop;

  // ---------------------------------------------------------------------------
  // Configuration: limits are stored saturated and minus one.
  assign cfg_ready_o = 1'b1;
  assign cfg_w       = cfg_data_i[sg3_pkg::WidthW-1:0];

  always_comb begin
    cfg_w_sat = cfg_w;
    if (cfg_w < sg3_pkg::MinWidth) begin
      cfg_w_sat = sg3_pkg::MinWidth;
    end else if (cfg_w > sg3_pkg::MaxWidthVal) begin
      cfg_w_sat = sg3_pkg::MaxWidthVal;
    end
    cfg_h_sat = (cfg_data_i < sg3_pkg::MinHeight) ? sg3_pkg::MinHeight : cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      wlim_q <= sg3_pkg::WidthLimReset;
      hlim_q <= sg3_pkg::HeightLimReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sg3_pkg::cfg_idx_e'(cfg_index_i))
        sg3_pkg::CfgMode:   mode_q <= cfg_data_i[0];
        sg3_pkg::CfgWidth:  wlim_q <= sg3_pkg::ColW'(cfg_w_sat - sg3_pkg::WidthW'(1));
        sg3_pkg::CfgHeight: hlim_q <= cfg_h_sat - sg3_pkg::RowW'(1);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, count position, issue the line buffer read.
  assign occ = sg3_pkg::OccW'(cnt_q) + sg3_pkg::OccW'(p1_valid_q & p1_emit_q)
             + sg3_pkg::OccW'(p2_valid_q);
  assign in_stall_o = (occ >= sg3_pkg::OccW'(sg3_pkg::FifoDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign row_end    = (col_q >= wlim_q);
  assign frame_end  = row_end && (row_q >= hlim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + sg3_pkg::RowW'(1);
      end else begin
        col_q <= col_q + sg3_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p1_emit_q  <= 1'b0;
      p1_last_q  <= 1'b0;
    end else begin
      p1_valid_q <= accept;
      if (accept) begin
        p1_emit_q <= (row_q >= sg3_pkg::RowW'(2)) && (col_q >= sg3_pkg::ColW'(2));
        p1_last_q <= frame_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_px_q   <= pixel_i;
      p1_addr_q <= col_q;
    end
  end

  // Each column is read in stage 0 and written back from stage 1. Two consecutive
  // pixels never share a column (a row has at least three), so no forwarding is needed.
  assign wr_word.two_above = rd_q.above;
  assign wr_word.above     = p1_px_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (p1_valid_q) begin
      line_mem[p1_addr_q] <= wr_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: shift the window left and load the new column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      p2_valid_q <= 1'b0;
      p2_last_q  <= 1'b0;
    end else begin
      p2_valid_q <= p1_valid_q && p1_emit_q;
      if (p1_valid_q) begin
        for (int k = 0; k < 3; k++) begin
          win_q[3*k]   <= win_q[3*k+1];
          win_q[3*k+1] <= win_q[3*k+2];
        end
        win_q[2]  <= rd_q.two_above;
        win_q[5]  <= rd_q.above;
        win_q[8]  <= p1_px_q;
        p2_last_q <= p1_last_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: separable kernel on the window, absolute value, divide by four.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (mode_q) begin
        col_a[j] = $signed({4'b0, win_q[j]}) + $signed({3'b0, win_q[3+j], 1'b0})
                 + $signed({4'b0, win_q[6+j]});
      end else begin
        col_a[j] = $signed({4'b0, win_q[6+j]}) - $signed({4'b0, win_q[j]});
      end
    end
    if (mode_q) begin
      sum = col_a[2] - col_a[0];
    end else begin
      sum = col_a[0] + (col_a[1] <<< 1) + col_a[2];
    end
    mag = sum[sg3_pkg::SumW-1] ? sg3_pkg::SumW'(-sum) : sg3_pkg::SumW'(sum);
    // The sum stays within +/-1020, so the quotient always fits in eight bits.
    res.gradient = mag[sg3_pkg::PixW+1:2];
    res.last     = p2_last_q;
  end

  // ---------------------------------------------------------------------------
  // Result queue; input stall counts every word still in flight toward it.
  assign push        = p2_valid_q;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign gradient_o  = fifo_q[rd_ptr_q].gradient;
  assign last_o      = fifo_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + sg3_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + sg3_pkg::FifoPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + sg3_pkg::FifoCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - sg3_pkg::FifoCntW'(1);
      end
    end
  end

endmodule

// File: verif/sg3_gradient_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 3x3 Sobel gradient block. It mirrors the line buffers, window,
// counters and registers, predicts one word per interior pixel and checks the output.
// Depends on sg3_pkg for the register indexes, the widths and the result word layout.
module sg3_gradient_checker
  import sg3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pixel_valid_i,
  input  logic                pixel_stall_i,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                grad_valid_i,
  input  logic                grad_stall_i,
  input  logic [PixW-1:0]     gradient_i,
  input  logic                last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  logic              mode_q;
  logic [WidthW-1:0] width_q;
  logic [RowW-1:0]   height_q;
  logic [PixW-1:0]   above_mem [MaxWidth];
  logic [PixW-1:0]   two_above_mem [MaxWidth];
  logic [PixW-1:0]   win [9];
  int unsigned       col_q;
  int unsigned       row_q;
  result_t           gradients_due [$];
  int unsigned       mismatches;

  function automatic int unsigned row_length();
    if (width_q < MinWidth) return 3;
    if (width_q > MaxWidthVal) return MaxWidth;
    return width_q;
  endfunction

  function automatic int unsigned frame_rows();
    if (height_q < MinHeight) return 3;
    return height_q;
  endfunction

  // Window row 0 is two rows up; column 2 holds the newest column.
  function automatic logic [PixW-1:0] sobel_magnitude();
    int top, mid, bot, sum, j;
    int part [3];
    for (j = 0; j < 3; j++) begin
      top = win[j];
      mid = win[3 + j];
      bot = win[6 + j];
      part[j] = mode_q ? top + 2 * mid + bot : bot - top;
    end
    sum = mode_q ? part[2] - part[0] : part[0] + 2 * part[1] + part[2];
    if (sum < 0) sum = -sum;
    sum = sum / 4;
    if (sum > 255) sum = 255;
    return PixW'(sum);
  endfunction

  function automatic void take_pixel(logic [PixW-1:0] px);
    int unsigned     len, rows, k, ci;
    logic [PixW-1:0] top, mid;
    logic            row_end, frame_end;
    result_t         word;
    len = row_length();
    rows = frame_rows();
    ci = col_q % MaxWidth;
    top = two_above_mem[ci];
    mid = above_mem[ci];
    row_end = col_q >= len - 1;
    frame_end = row_end && row_q >= rows - 1;
    two_above_mem[ci] = mid;
    above_mem[ci] = px;
    for (k = 0; k < 3; k++) begin
      win[3 * k] = win[3 * k + 1];
      win[3 * k + 1] = win[3 * k + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (row_q >= 2 && col_q >= 2) begin
      word.gradient = sobel_magnitude();
      word.last = frame_end;
      gradients_due.push_back(word);
    end
    if (row_end) begin
      col_q = 0;
      row_q = frame_end ? 0 : (row_q + 1) & 32'hFFF;
    end else begin
      col_q++;
    end
  endfunction

  function automatic void check_word();
    result_t want;
    if (gradients_due.size() == 0) begin
      mismatches++;
      $display("%0t: expected no word, got gradient %0d last %0b", $time, gradient_i, last_i);
      return;
    end
    want = gradients_due.pop_front();
    if (gradient_i !== want.gradient) begin
      mismatches++;
      $display("%0t: gradient expected %0d, got %0d", $time, want.gradient, gradient_i);
    end
    if (last_i !== want.last) begin
      mismatches++;
      $display("%0t: last expected %0b, got %0b", $time, want.last, last_i);
    end
  endfunction

  function automatic void take_config();
    case (cfg_idx_e'(cfg_index_i))
      CfgMode:   mode_q = cfg_data_i[0];
      CfgWidth:  width_q = cfg_data_i[WidthW-1:0];
      CfgHeight: height_q = cfg_data_i[RowW-1:0];
      default: ;
    endcase
  endfunction

  // Words leave the block only after their pixel has passed its registers, so the
  // output side is checked before the pixel of the same edge adds its expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = 1'b0;
      width_q = WidthW'(640);
      height_q = RowW'(480);
      win = '{default: '0};
      col_q = 0;
      row_q = 0;
      gradients_due.delete();
      mismatches = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) take_config();
      if (grad_valid_i && !grad_stall_i) check_word();
      if (pixel_valid_i && !pixel_stall_i) take_pixel(pixel_i);
      mismatches_o <= mismatches;
      pending_o <= gradients_due.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the Sobel gradient testbench: clock, reset, pixel and register stimulus, and
// the output stall pattern. Depends on sg3_pkg, sobel_gradient_3x3_top and sg3_gradient_checker.
module testbench;
  import sg3_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int RunLimitNs  = 2_000_000;
  localparam int DrainCycles = 8;
  localparam int LongHold    = 150;
  localparam int RandomItems = 250;

  typedef enum int {PixUniform, PixExtreme, PixSmooth} pix_style_e;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                pixel_valid = 1'b0;
  logic                pixel_stall;
  logic [PixW-1:0]     pixel = '0;
  logic                grad_valid;
  logic                grad_stall = 1'b0;
  logic [PixW-1:0]     gradient;
  logic                last_flag;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CfgMode;
  logic [CfgDataW-1:0] cfg_data = '0;
  int unsigned         mismatches;
  int unsigned         pending;

  // Stimulus bookkeeping: register copies and the raster position of the next pixel.
  logic [WidthW-1:0]   width_set = WidthW'(640);
  logic [RowW-1:0]     height_set = RowW'(480);
  int                  pos_col = 0;
  int                  pos_row = 0;
  int                  burst_left = 0;
  int                  items_sent = 0;
  logic [PixW-1:0]     smooth_level = 8'd128;
  int                  outputs_taken = 0;
  int                  hold_mark = -1;
  logic                long_hold_done = 1'b0;

  sobel_gradient_3x3_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pixel_valid),
    .in_stall_o  (pixel_stall),
    .pixel_i     (pixel),
    .out_valid_o (grad_valid),
    .out_stall_i (grad_stall),
    .gradient_o  (gradient),
    .last_o      (last_flag),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sg3_gradient_checker check_grad (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .pixel_valid_i (pixel_valid),
    .pixel_stall_i (pixel_stall),
    .pixel_i       (pixel),
    .grad_valid_i  (grad_valid),
    .grad_stall_i  (grad_stall),
    .gradient_i    (gradient),
    .last_i        (last_flag),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  initial begin
    #(RunLimitNs);
    $display("FAIL");
    $finish;
  end

  function automatic int row_px();
    if (width_set < MinWidth) return 3;
    if (width_set > MaxWidthVal) return MaxWidth;
    return width_set;
  endfunction

  function automatic int frame_rows();
    if (height_set < MinHeight) return 3;
    return height_set;
  endfunction

  function automatic logic [PixW-1:0] make_pixel(pix_style_e style);
    case (style)
      PixExtreme: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      PixSmooth: begin
        smooth_level = smooth_level + 8'($urandom_range(0, 8)) - 8'd4;
        return smooth_level;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgWidth:  width_set = value[WidthW-1:0];
      CfgHeight: height_set = value[RowW-1:0];
      default: ;
    endcase
  endtask

  // The sender works in bursts; a gap only opens between bursts.
  task automatic send_pixel(logic [PixW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 20);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    do @(posedge clk); while (pixel_stall);
    burst_left--;
    items_sent++;
    if (pos_col >= row_px() - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= frame_rows() - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic finish_frame(pix_style_e style);
    do send_pixel(make_pixel(style)); while (pos_col != 0 || pos_row != 0);
  endtask

  // Waits until every predicted word has come out, then lets the pipeline settle.
  task automatic drain();
    pixel_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin : grad_receiver
    int style, span, tick, period;
    wait (rst_n === 1'b1);
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      period = $urandom_range(2, 5);
      for (tick = 0; tick < span; tick++) begin
        // One long hold-off so that the result queue fills and the input stalls.
        if (!long_hold_done && hold_mark >= 0 && outputs_taken >= hold_mark) begin
          long_hold_done = 1'b1;
          grad_stall <= 1'b1;
          repeat (LongHold) @(posedge clk);
        end
        case (style)
          0: grad_stall <= 1'b0;
          1: grad_stall <= ($urandom_range(0, 3) == 0);
          2: grad_stall <= ($urandom_range(0, 1) == 0);
          default: grad_stall <= (tick % period == 0);
        endcase
        @(posedge clk);
        if (grad_valid && !grad_stall) outputs_taken++;
      end
    end
  end

  initial begin : stimulus
    logic [PixW-1:0] seq [$];
    int              random_start, w, h, cut, px_count;
    pix_style_e      style;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Start of a row at the power-up width, then shrink the row mid-frame so that
    // it ends at once; mode 0 from reset gives the largest positive gradient.
    repeat (6) send_pixel(8'd0);
    drain();
    write_reg(CfgWidth, 12'd3);
    write_reg(CfgHeight, 12'd3);
    seq = '{8'd0, 8'd9, 8'd9, 8'd9, 8'd255, 8'd255, 8'd255};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();

    // Transposed kernel, largest negative sum and a mid-range one.
    write_reg(CfgMode, 12'd1);
    write_reg(CfgHeight, 12'd4);
    seq = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd254, 8'd0,
            8'd0, 8'd255, 8'd255};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();

    // Width below the minimum, tallest frame, then the height is cut below the
    // current row so the frame closes at the end of that row.
    write_reg(CfgWidth, 12'd1);
    write_reg(CfgHeight, 12'd4095);
    repeat (12) send_pixel(make_pixel(PixUniform));
    drain();
    write_reg(CfgHeight, 12'd0);
    finish_frame(PixUniform);
    drain();

    // Widest row: all twelve data bits set saturate the width to the maximum. After
    // one full row at that width the row shrinks, and the long output hold-off falls
    // within the rest of the frame.
    write_reg(CfgWidth, 12'hFFF);
    write_reg(CfgHeight, 12'd4);
    write_reg(CfgMode, 12'hFFE);
    repeat (MaxWidth) send_pixel(make_pixel(PixUniform));
    drain();
    write_reg(CfgWidth, 12'd32);
    hold_mark = outputs_taken + 5;
    finish_frame(PixUniform);
    drain();

    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      if ($urandom_range(0, 2) != 0) write_reg(CfgMode, 12'($urandom()));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: w = $urandom_range(0, 2);
          1: w = $urandom_range(13, 40);
          2: w = 3;
          default: w = $urandom_range(3, 12);
        endcase
        write_reg(CfgWidth, {1'($urandom_range(0, 1)), 11'(w)});
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: h = $urandom_range(0, 2);
          1: h = 3;
          default: h = $urandom_range(3, 7);
        endcase
        write_reg(CfgHeight, 12'(h));
      end
      style = pix_style_e'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        // Break the frame: pause, change a register, then carry on to its end.
        // The row may not grow here, since longer rows would read unwritten columns.
        px_count = row_px() * frame_rows();
        cut = $urandom_range(1, px_count - 1);
        repeat (cut) send_pixel(make_pixel(style));
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(CfgMode, 12'($urandom()));
          1: write_reg(CfgHeight, 12'($urandom_range(0, 9)));
          default: write_reg(CfgWidth, 12'($urandom_range(0, row_px())));
        endcase
        if (pos_col != 0 || pos_row != 0) finish_frame(style);
      end else begin
        finish_frame(style);
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sg3_pkg.sv
rtl/core/sobel_gradient_3x3_top.sv
verif/sg3_gradient_checker.sv
verif/testbench.sv
